// ===== rtl/mbp_pkg.sv =====
// package for the msb-first bit packer: beat types, constants and the microcode table
package mbp_pkg;

  localparam int MAX_PUT_BITS = 32;
  localparam int BYTE_BITS    = 8;
  localparam int WORD_BITS    = 32;
  localparam int PUT_LIMIT_I  = (MAX_PUT_BITS < WORD_BITS) ? MAX_PUT_BITS : WORD_BITS;
  localparam int COUNT_W      = 6;
  localparam int FREE_W       = 4;
  localparam logic [COUNT_W-1:0] PUT_LIMIT = COUNT_W'(PUT_LIMIT_I);

  localparam logic OP_PUT    = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [WORD_BITS-1:0] value;
    logic [COUNT_W-1:0]   bit_count;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 last_byte;
  } out_item_t;

  // microcode step addresses
  localparam int STEP_W = 2;
  localparam logic [STEP_W-1:0] STEP_IDLE = 2'd0;
  localparam logic [STEP_W-1:0] STEP_PUT  = 2'd1;
  localparam logic [STEP_W-1:0] STEP_FIN  = 2'd2;

  typedef enum logic [1:0] {
    J_ALWAYS    = 2'd0,
    J_IF_FINISH = 2'd1,
    J_IF_MORE   = 2'd2
  } jump_t;

  typedef struct packed {
    logic              accept;
    logic              wait_out;
    logic              merge;
    logic              flush;
    jump_t             jump;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // strobes into the datapath, already gated by the sequencer
  typedef struct packed {
    logic load;
    logic merge;
    logic flush;
  } dp_ctrl_t;

  typedef struct packed {
    logic      emit;
    logic      more;
    out_item_t item;
  } dp_stat_t;

  function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{accept: 1'b0, wait_out: 1'b0, merge: 1'b0, flush: 1'b0,
          jump: J_ALWAYS, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.accept = 1'b1;
        w.jump   = J_IF_FINISH;
        w.target = STEP_PUT;
      end
      STEP_PUT: begin
        w.wait_out = 1'b1;
        w.merge    = 1'b1;
        w.jump     = J_IF_MORE;
        w.target   = STEP_PUT;
      end
      STEP_FIN: begin
        w.wait_out = 1'b1;
        w.flush    = 1'b1;
        w.jump     = J_ALWAYS;
        w.target   = STEP_IDLE;
      end
      default: begin
        w.jump   = J_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/mbp_datapath.sv =====
// bit packer datapath: pending byte, free count, aligned value and remaining count
module mbp_datapath import mbp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dp_ctrl_t ctrl,
  input  in_item_t item,
  output dp_stat_t stat
);

  logic [BYTE_BITS-1:0] pending;
  logic [FREE_W-1:0]    free;
  logic [WORD_BITS-1:0] aligned;
  logic [COUNT_W-1:0]   remain;

  logic [COUNT_W-1:0]   n_sat;
  logic [BYTE_BITS-1:0] chunk;
  logic [BYTE_BITS-1:0] merged;
  logic                 full;
  logic [COUNT_W-1:0]   rem_after;

  always_comb begin
    n_sat = (item.bit_count > PUT_LIMIT) ? PUT_LIMIT : item.bit_count;
    // top free bits of the aligned value land in the free low end of the pending byte
    chunk     = aligned[WORD_BITS-1 -: BYTE_BITS] >> (FREE_W'(BYTE_BITS) - free);
    merged    = pending | chunk;
    full      = remain >= {{(COUNT_W-FREE_W){1'b0}}, free};
    rem_after = full ? (remain - {{(COUNT_W-FREE_W){1'b0}}, free}) : '0;
  end

  always_comb begin
    stat = '0;
    stat.more = rem_after != '0;
    if (ctrl.merge) begin
      stat.emit           = full;
      stat.item.out_byte  = merged;
      // fewer than a byte left cannot fill another one
      stat.item.last_byte = rem_after < COUNT_W'(BYTE_BITS);
    end else if (ctrl.flush) begin
      stat.emit           = free != FREE_W'(BYTE_BITS);
      stat.item.out_byte  = pending;
      stat.item.last_byte = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      free    <= FREE_W'(BYTE_BITS);
      remain  <= '0;
    end else if (ctrl.load) begin
      remain <= n_sat;
    end else if (ctrl.merge) begin
      remain <= rem_after;
      if (full) begin
        pending <= '0;
        free    <= FREE_W'(BYTE_BITS);
      end else begin
        pending <= merged;
        free    <= free - remain[FREE_W-1:0];
      end
    end else if (ctrl.flush) begin
      pending <= '0;
      free    <= FREE_W'(BYTE_BITS);
    end
  end

  // value kept top-aligned; shifting in zeros masks bits above the count
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      aligned <= item.value << (COUNT_W'(WORD_BITS) - n_sat);
    end else if (ctrl.merge) begin
      aligned <= aligned << free;
    end
  end

endmodule

// ===== rtl/msb_first_bit_packer_top.sv =====
// msb-first bit packer: packs put values into a byte stream, top bit of each byte first.
// A put of n bits (n above 32 saturates) is accepted in the idle step, then takes one microcode
// step per chunk: a chunk fills the pending byte or holds the trailing bits (a zero-bit put
// still takes one step), and a finish is accepted and then drains in the flush step. A step
// that may emit waits while the output register holds a stalled byte. The output
// register parts the channels, so the next item is taken while the last byte still
// waits downstream. last_byte marks the final byte of each input item.
module msb_first_bit_packer_top import mbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ctrl_t             ctrl;
  logic              fire;
  logic              take;
  dp_ctrl_t          dp_ctrl;
  dp_stat_t          dp_stat;

  always_comb begin
    ctrl     = ucode_rom(step);
    fire     = !(ctrl.wait_out && out_valid && out_stall);
    in_stall = !ctrl.accept;
    take     = ctrl.accept && in_valid;

    dp_ctrl.load  = take && (in_data.operation == OP_PUT);
    dp_ctrl.merge = fire && ctrl.merge;
    dp_ctrl.flush = fire && ctrl.flush;

    step_next = step;
    if (fire) begin
      unique case (ctrl.jump)
        J_ALWAYS:    step_next = ctrl.target;
        J_IF_FINISH: begin
          if (take) begin
            step_next = (in_data.operation == OP_FINISH) ? STEP_FIN : ctrl.target;
          end
        end
        J_IF_MORE:   step_next = dp_stat.more ? ctrl.target : STEP_IDLE;
        default:     step_next = STEP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  mbp_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .ctrl (dp_ctrl),
    .item (in_data),
    .stat (dp_stat)
  );

  // output register, loaded only when the slot is free or draining this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_stat.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_stat.emit) begin
      out_data <= dp_stat.item;
    end
  end

endmodule
